/* rtl/rgb_to_hsv_hsl_hsi_convert_macros.svh */
// Assertion macros for the checker file.
`ifndef RGB_TO_HSV_HSL_HSI_CONVERT_MACROS_SVH
`define RGB_TO_HSV_HSL_HSI_CONVERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RHC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while in reset.
`define RHC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* rtl/rhc_pkg.sv */
package rhc_pkg;

  // Default channel width of a pixel
  localparam int CHANNEL_BITS_DEF = 8;

  // Hue field, whole degrees 0..360
  localparam int HUE_BITS = 9;
  localparam logic [HUE_BITS-1:0] HUE_MAX = HUE_BITS'(360);

  // Register port geometry
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Register word indexes
  localparam logic [CFG_AW-3:0] REG_MODE = '0;

  // Mode codes; anything above HSL selects HSI
  localparam logic [1:0] MODE_HSV = 2'd0;
  localparam logic [1:0] MODE_HSL = 2'd1;
  localparam logic [1:0] MODE_HSI = 2'd2;

endpackage

/* rtl/rhc_ifs.sv */
// Pixel input channel
interface rhc_pix_if #(
  parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// Hue / saturation / brightness result channel
interface rhc_hsx_if #(
  parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [rhc_pkg::HUE_BITS-1:0] hue;
  logic [CHANNEL_BITS-1:0]      saturation;
  logic [CHANNEL_BITS-1:0]      brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

/* rtl/rhc_div.sv */
// Twin restoring divider, one quotient bit per register stage.
// Lane h forms the hue quotient, lane s the saturation quotient;
// brightness rides along. Every stage holds its own valid bit.
module rhc_div #(
  parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [CHANNEL_BITS+9:0]      hnum,
  input  logic [CHANNEL_BITS:0]        hden,
  input  logic [2*CHANNEL_BITS:0]      snum,
  input  logic [CHANNEL_BITS:0]        sden,
  input  logic [CHANNEL_BITS-1:0]      bri,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rhc_pkg::HUE_BITS-1:0] hue,
  output logic [CHANNEL_BITS-1:0]      sat,
  output logic [CHANNEL_BITS-1:0]      bri_o
);

  localparam int CB  = CHANNEL_BITS;
  localparam int QW  = (CB > rhc_pkg::HUE_BITS) ? CB : rhc_pkg::HUE_BITS;
  localparam int HNW = CB + 10;
  localparam int SNW = 2 * CB + 1;
  localparam int DW  = CB + 1;
  localparam int HXW = HNW + QW;
  localparam int SXW = SNW + QW;

  logic [QW-1:0]  v_r;
  logic [QW:0]    rdy;
  logic [HNW-1:0] hrem_r [QW-1];
  logic [SNW-1:0] srem_r [QW-1];
  logic [DW-1:0]  hd_r   [QW-1];
  logic [DW-1:0]  sd_r   [QW-1];
  logic [QW-1:0]  hq_r   [QW];
  logic [QW-1:0]  sq_r   [QW];
  logic [CB-1:0]  b_r    [QW];

  assign rdy[QW]  = out_ready;
  assign in_ready = rdy[0];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int J = QW - 1 - k;

    logic           v_in;
    logic [HNW-1:0] hrem_in;
    logic [SNW-1:0] srem_in;
    logic [DW-1:0]  hd_in;
    logic [DW-1:0]  sd_in;
    logic [QW-1:0]  hq_in;
    logic [QW-1:0]  sq_in;
    logic [CB-1:0]  b_in;
    logic [HXW-1:0] hsh;
    logic [SXW-1:0] ssh;
    logic           hge;
    logic           sge;
    logic [HNW-1:0] hrem_nxt;
    logic [SNW-1:0] srem_nxt;
    logic [QW-1:0]  hq_nxt;
    logic [QW-1:0]  sq_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign hrem_in = hnum;
      assign srem_in = snum;
      assign hd_in   = hden;
      assign sd_in   = sden;
      assign hq_in   = '0;
      assign sq_in   = '0;
      assign b_in    = bri;
    end else begin : g_rest
      assign v_in    = v_r[k-1];
      assign hrem_in = hrem_r[k-1];
      assign srem_in = srem_r[k-1];
      assign hd_in   = hd_r[k-1];
      assign sd_in   = sd_r[k-1];
      assign hq_in   = hq_r[k-1];
      assign sq_in   = sq_r[k-1];
      assign b_in    = b_r[k-1];
    end

    // Trial subtract of the shifted divisor, set one quotient bit
    always_comb begin
      hsh      = HXW'(hd_in) << J;
      ssh      = SXW'(sd_in) << J;
      hge      = HXW'(hrem_in) >= hsh;
      sge      = SXW'(srem_in) >= ssh;
      hrem_nxt = hge ? HNW'(HXW'(hrem_in) - hsh) : hrem_in;
      srem_nxt = sge ? SNW'(SXW'(srem_in) - ssh) : srem_in;
      hq_nxt    = hq_in;
      hq_nxt[J] = hge;
      sq_nxt    = sq_in;
      sq_nxt[J] = sge;
    end

    // Stage may load when empty or when its content moves on
    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v_in) begin
        hq_r[k] <= hq_nxt;
        sq_r[k] <= sq_nxt;
        b_r[k]  <= b_in;
      end
    end

    // Remainder and divisor are dead after the last bit
    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (rdy[k] && v_in) begin
          hrem_r[k] <= hrem_nxt;
          srem_r[k] <= srem_nxt;
          hd_r[k]   <= hd_in;
          sd_r[k]   <= sd_in;
        end
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign hue       = hq_r[QW-1][rhc_pkg::HUE_BITS-1:0];
  assign sat       = sq_r[QW-1][CB-1:0];
  assign bri_o     = b_r[QW-1];

endmodule

/* rtl/rgb_to_hsv_hsl_hsi_convert.sv */
// Channel  | Dir | Payload                          | Handshake
// in_ch    | in  | red, green, blue                 | valid/ready
// out_ch   | out | hue, saturation, brightness      | valid/ready
// cfg_*    | in  | mode register at word 0          | APB write/read
//
// One pixel per cycle sustained while out_ch is ready. Three front stages, then one
// divider stage per quotient bit, Q = max(9, CHANNEL_BITS) quotient bits.
// Synchronous active-low reset clears all valid bits and sets mode to HSV.
// Each stage advances when it is empty or the next one takes its content, so
// bubbles fill under a stall and no pixel is dropped or repeated.
module rgb_to_hsv_hsl_hsi_convert #(
  parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  rhc_pix_if.sink                    in_ch,
  rhc_hsx_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [rhc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [rhc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [rhc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int CB  = CHANNEL_BITS;
  localparam int SW  = CB + 2;
  localparam int K   = SW + 2;
  localparam int TW  = CB + 10;
  localparam int HNW = CB + 10;
  localparam int SNW = 2 * CB + 1;
  localparam int DW  = CB + 1;
  localparam int PW  = 2 * SW + 1;
  localparam logic [SW:0]           RECIP3 = (SW+1)'(((longint'(1) << K) + 2) / 3);
  localparam logic [CB-1:0]         PIX    = '1;
  localparam logic signed [TW-1:0]  C60    = TW'(60);
  localparam logic signed [TW-1:0]  C120   = TW'(120);
  localparam logic signed [TW-1:0]  C240   = TW'(240);
  localparam logic signed [TW-1:0]  C360   = TW'(360);

  typedef enum logic [1:0] {SEC_RED, SEC_GREEN, SEC_BLUE} sector_t;

  // ---------------- register port ----------------
  logic [1:0] mode_r;
  logic       cfg_wr;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[rhc_pkg::CFG_AW-1:2] == rhc_pkg::REG_MODE) ?
                      rhc_pkg::CFG_DW'(mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rhc_pkg::MODE_HSV;
    end else if (cfg_wr && cfg_paddr[rhc_pkg::CFG_AW-1:2] == rhc_pkg::REG_MODE) begin
      mode_r <= cfg_pwdata[1:0];
    end
  end

  // ---------------- stage 1: max, min, sector ----------------
  logic                 rdy1, rdy2, rdy3, div_rdy;
  logic [CB-1:0]        mx1, mn1;
  sector_t              sec1;
  logic signed [CB:0]   dif1;
  logic [SW-1:0]        sum1;

  logic                 v1_r;
  logic [CB-1:0]        mx1_r, mn1_r;
  sector_t              sec1_r;
  logic signed [CB:0]   dif1_r;
  logic [SW-1:0]        sum1_r;
  logic [1:0]           mode1_r;

  always_comb begin
    mx1 = in_ch.red;
    mn1 = in_ch.red;
    if (in_ch.green > mx1) mx1 = in_ch.green;
    if (in_ch.green < mn1) mn1 = in_ch.green;
    if (in_ch.blue > mx1)  mx1 = in_ch.blue;
    if (in_ch.blue < mn1)  mn1 = in_ch.blue;
    if (mx1 == in_ch.red) begin
      sec1 = SEC_RED;
      dif1 = $signed({1'b0, in_ch.green}) - $signed({1'b0, in_ch.blue});
    end else if (mx1 == in_ch.green) begin
      sec1 = SEC_GREEN;
      dif1 = $signed({1'b0, in_ch.blue}) - $signed({1'b0, in_ch.red});
    end else begin
      sec1 = SEC_BLUE;
      dif1 = $signed({1'b0, in_ch.red}) - $signed({1'b0, in_ch.green});
    end
    sum1 = SW'(in_ch.red) + SW'(in_ch.green) + SW'(in_ch.blue);
  end

  assign rdy1        = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      mx1_r   <= mx1;
      mn1_r   <= mn1;
      sec1_r  <= sec1;
      dif1_r  <= dif1;
      sum1_r  <= sum1;
      mode1_r <= mode_r;
    end
  end

  // ---------------- stage 2: hue numerator, intensity ----------------
  logic [CB-1:0]         d2;
  logic signed [TW-1:0]  dd2, t2;
  logic [PW-1:0]         prod2;

  logic                  v2_r;
  logic [CB-1:0]         d2_r, mx2_r, mn2_r, int2_r;
  logic [TW-2:0]         t2_r;
  logic [1:0]            mode2_r;

  always_comb begin
    d2  = mx1_r - mn1_r;
    dd2 = $signed(TW'(d2));
    t2  = TW'(dif1_r) * C60;
    case (sec1_r)
      SEC_GREEN: t2 = t2 + C120 * dd2;
      SEC_BLUE:  t2 = t2 + C240 * dd2;
      default:   t2 = t2;
    endcase
    // Wrap negative hue by a full turn
    if (t2 < 0) t2 = t2 + C360 * dd2;
    // Divide the channel sum by three through a reciprocal
    prod2 = PW'(sum1_r) * PW'(RECIP3);
  end

  assign rdy2 = !v2_r || rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      d2_r    <= d2;
      t2_r    <= t2[TW-2:0];
      mx2_r   <= mx1_r;
      mn2_r   <= mn1_r;
      int2_r  <= prod2[K +: CB];
      mode2_r <= mode1_r;
    end
  end

  // ---------------- stage 3: dividends and divisors ----------------
  logic [CB:0]     sl3, adev3, pixw3;
  logic [CB-1:0]   den3, x3, bri3;
  logic            ok3;
  logic [2*CB-1:0] num3;
  logic [HNW-1:0]  hn3;
  logic [DW-1:0]   hd3, sd3;
  logic [SNW-1:0]  sn3;

  logic            v3_r;
  logic [HNW-1:0]  hn3_r;
  logic [DW-1:0]   hd3_r, sd3_r;
  logic [SNW-1:0]  sn3_r;
  logic [CB-1:0]   bri3_r;

  always_comb begin
    // Gray pixel: force a zero quotient
    if (d2_r == '0) begin
      hn3 = '0;
      hd3 = DW'(1);
    end else begin
      hn3 = HNW'({t2_r, 1'b0}) + HNW'(d2_r);
      hd3 = {d2_r, 1'b0};
    end

    sl3   = DW'(mx2_r) + DW'(mn2_r);
    pixw3 = DW'(PIX);
    adev3 = (sl3 >= pixw3) ? sl3 - pixw3 : pixw3 - sl3;

    case (mode2_r)
      rhc_pkg::MODE_HSV: begin
        ok3  = mx2_r != '0;
        den3 = mx2_r;
        x3   = d2_r;
        bri3 = mx2_r;
      end
      rhc_pkg::MODE_HSL: begin
        den3 = CB'(pixw3 - adev3);
        ok3  = d2_r != '0 && den3 != '0;
        x3   = d2_r;
        bri3 = sl3[CB:1];
      end
      default: begin
        ok3  = int2_r != '0 && int2_r >= mn2_r;
        den3 = int2_r;
        x3   = int2_r - mn2_r;
        bri3 = int2_r;
      end
    endcase

    // Scale by full scale: x * (2^CB - 1)
    num3 = {x3, {CB{1'b0}}} - (2*CB)'(x3);
    if (ok3) begin
      sn3 = {num3, 1'b0} + SNW'(den3);
      sd3 = {den3, 1'b0};
    end else begin
      sn3 = '0;
      sd3 = DW'(1);
    end
  end

  assign rdy3 = !v3_r || div_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      hn3_r  <= hn3;
      hd3_r  <= hd3;
      sn3_r  <= sn3;
      sd3_r  <= sd3;
      bri3_r <= bri3;
    end
  end

  // ---------------- divider pipeline, rounded quotients ----------------
  rhc_div #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (div_rdy),
    .hnum      (hn3_r),
    .hden      (hd3_r),
    .snum      (sn3_r),
    .sden      (sd3_r),
    .bri       (bri3_r),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .hue       (out_ch.hue),
    .sat       (out_ch.saturation),
    .bri_o     (out_ch.brightness)
  );

endmodule

/* rtl/rhc_check.sv */
`include "rgb_to_hsv_hsl_hsi_convert_macros.svh"

// Port-level checks on the converter
module rhc_check #(
  parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rhc_pkg::HUE_BITS-1:0] hue,
  input logic [CHANNEL_BITS-1:0]      saturation,
  input logic [CHANNEL_BITS-1:0]      brightness
);

  // Hold a stalled result
  `RHC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(hue) && $stable(saturation) && $stable(brightness))

  // Hue stays within a full turn
  `RHC_ASSERT_IMP(a_hue_range, clk, rst_n, out_valid, hue <= rhc_pkg::HUE_MAX)

  // Drop all results on reset
  `RHC_ASSERT_IMP(a_reset_empty, clk, rst_n, $past(!rst_n), !out_valid)

  // An empty output stage means the whole pipe can take a pixel
  `RHC_ASSERT_IMP(a_ready_when_drained, clk, rst_n, !out_valid, in_ready)

endmodule

bind rgb_to_hsv_hsl_hsi_convert rhc_check #(
  .CHANNEL_BITS (CHANNEL_BITS)
) u_rhc_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .hue        (out_ch.hue),
  .saturation (out_ch.saturation),
  .brightness (out_ch.brightness)
);

/* test/tb_rgb_to_hsv_hsl_hsi_convert.sv */
module tb_rgb_to_hsv_hsl_hsi_convert;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = rhc_pkg::CHANNEL_BITS_DEF;
  localparam int PMAX = (1 << CB) - 1;
  localparam int LATENCY = 3 + ((CB > 9) ? CB : 9);
  localparam int N_RANDOM = 1100;

  typedef struct packed {
    logic [rhc_pkg::HUE_BITS-1:0] hue;
    logic [CB-1:0]                saturation;
    logic [CB-1:0]                brightness;
  } hsx_t;

  // Directed pixel with an optional typed-in result
  typedef struct {
    logic [1:0]    mode;
    logic [CB-1:0] r;
    logic [CB-1:0] g;
    logic [CB-1:0] b;
    bit            known;
    hsx_t          res;
  } pix_row_t;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [rhc_pkg::CFG_AW-1:0] cfg_paddr;
  logic [rhc_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [rhc_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  rhc_pix_if #(.CHANNEL_BITS(CB)) pix_ch ();
  rhc_hsx_if #(.CHANNEL_BITS(CB)) hsx_ch ();

  rgb_to_hsv_hsl_hsi_convert #(.CHANNEL_BITS(CB)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (pix_ch.sink),
    .out_ch     (hsx_ch.source),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  logic [1:0] mode_shadow;
  hsx_t       hsx_expected[$];
  int         mismatches;
  int         spurious;
  bit         hold_long;

  // Generate the clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bound the run
  initial begin
    #40ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Rounded-half-up quotient of nonnegative n over positive d
  function automatic longint div_round(longint n, longint d);
    return (2 * n + d) / (2 * d);
  endfunction

  // Compute hue, saturation and brightness for one pixel
  function automatic hsx_t hsx_of_pixel(logic [1:0] m, logic [CB-1:0] r8,
                                        logic [CB-1:0] g8, logic [CB-1:0] b8);
    longint r, g, b, mx, mn, d, t, hue, sat, bri, s, den, inten;
    hsx_t o;
    r = r8; g = g8; b = b8;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (g < mn) mn = g;
    if (b > mx) mx = b;
    if (b < mn) mn = b;
    d = mx - mn;
    hue = 0; sat = 0;
    if (d != 0) begin
      if (mx == r) t = 60 * (g - b);
      else if (mx == g) t = 120 * d + 60 * (b - r);
      else t = 240 * d + 60 * (r - g);
      if (t < 0) t += 360 * d;
      hue = div_round(t, d);
    end
    if (m == rhc_pkg::MODE_HSV) begin
      if (mx != 0) sat = div_round(d * PMAX, mx);
      bri = mx;
    end else if (m == rhc_pkg::MODE_HSL) begin
      s = mx + mn - PMAX;
      den = PMAX - ((s < 0) ? -s : s);
      if (d != 0 && den > 0) sat = div_round(d * PMAX, den);
      bri = (mx + mn) / 2;
    end else begin
      // Intensity first, then saturation from it
      inten = (r + g + b) / 3;
      if (inten != 0 && inten >= mn) sat = div_round((inten - mn) * PMAX, inten);
      bri = inten;
    end
    if (sat > PMAX) sat = PMAX;
    o.hue = hue[rhc_pkg::HUE_BITS-1:0];
    o.saturation = sat[CB-1:0];
    o.brightness = bri[CB-1:0];
    return o;
  endfunction

  // Write one register through the APB port
  task automatic reg_write(logic [rhc_pkg::CFG_AW-1:0] addr,
                           logic [rhc_pkg::CFG_DW-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr[rhc_pkg::CFG_AW-1:2] == rhc_pkg::REG_MODE) mode_shadow = data[1:0];
  endtask

  // Wait for the pipeline to drain before touching the mode
  task automatic drain();
    int guard;
    guard = 0;
    while (hsx_expected.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Offer one pixel, now and then after a random gap, and hold until the transfer
  task automatic send_pixel(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b,
                            bit known, hsx_t res);
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.red <= r;
    pix_ch.green <= g;
    pix_ch.blue <= b;
    do @(posedge clk); while (!pix_ch.ready);
    hsx_expected.push_back(known ? res : hsx_of_pixel(mode_shadow, r, g, b));
  endtask

  task automatic idle_pixel();
    pix_ch.valid <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    int hold;
    hsx_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_long) begin
        hsx_ch.ready <= 1'b0;
        hold = 0;
        while (hold < 150) begin
          @(posedge clk);
          hold++;
        end
        hold_long = 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
        hsx_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        hsx_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare every result transfer with the oldest expectation
  always @(posedge clk) begin
    hsx_t want;
    if (rst_n && hsx_ch.valid && hsx_ch.ready) begin
      if (hsx_expected.size() == 0) begin
        spurious++;
        if (mismatches + spurious <= 10)
          $display("unexpected result hue=%0d sat=%0d bri=%0d",
                   hsx_ch.hue, hsx_ch.saturation, hsx_ch.brightness);
      end else begin
        want = hsx_expected.pop_front();
        if (hsx_ch.hue !== want.hue || hsx_ch.saturation !== want.saturation ||
            hsx_ch.brightness !== want.brightness) begin
          mismatches++;
          if (mismatches + spurious <= 10)
            $display("mismatch: exp hue=%0d sat=%0d bri=%0d, got hue=%0d sat=%0d bri=%0d",
                     want.hue, want.saturation, want.brightness,
                     hsx_ch.hue, hsx_ch.saturation, hsx_ch.brightness);
        end
      end
    end
  end

  // Main stimulus
  initial begin
    pix_row_t rows[$];
    pix_row_t row;
    hsx_t none;
    logic [1:0] modes[4];
    logic [CB-1:0] lo, hi, mid;
    int k;
    none = '0;
    mismatches = 0;
    spurious = 0;
    hold_long = 1'b0;
    mode_shadow = rhc_pkg::MODE_HSV;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    pix_ch.valid = 1'b0;
    pix_ch.red = '0;
    pix_ch.green = '0;
    pix_ch.blue = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: extremes, gray, each sector, every mode
    rows = '{
      '{rhc_pkg::MODE_HSV, 8'd0,   8'd0,   8'd0,   1, '{9'd0,   8'd0,   8'd0}},
      '{rhc_pkg::MODE_HSV, 8'd255, 8'd255, 8'd255, 1, '{9'd0,   8'd0,   8'd255}},
      '{rhc_pkg::MODE_HSV, 8'd255, 8'd0,   8'd0,   1, '{9'd0,   8'd255, 8'd255}},
      '{rhc_pkg::MODE_HSV, 8'd0,   8'd255, 8'd0,   1, '{9'd120, 8'd255, 8'd255}},
      '{rhc_pkg::MODE_HSV, 8'd0,   8'd0,   8'd255, 1, '{9'd240, 8'd255, 8'd255}},
      '{rhc_pkg::MODE_HSV, 8'd255, 8'd0,   8'd1,   0, none},
      '{rhc_pkg::MODE_HSV, 8'd255, 8'd255, 8'd0,   0, none},
      '{rhc_pkg::MODE_HSV, 8'd128, 8'd128, 8'd128, 1, '{9'd0,   8'd0,   8'd128}},
      '{rhc_pkg::MODE_HSL, 8'd0,   8'd0,   8'd0,   1, '{9'd0,   8'd0,   8'd0}},
      '{rhc_pkg::MODE_HSL, 8'd255, 8'd0,   8'd0,   1, '{9'd0,   8'd255, 8'd127}},
      '{rhc_pkg::MODE_HSL, 8'd255, 8'd255, 8'd254, 0, none},
      '{rhc_pkg::MODE_HSL, 8'd1,   8'd0,   8'd0,   0, none},
      '{rhc_pkg::MODE_HSL, 8'd77,  8'd77,  8'd77,  1, '{9'd0,   8'd0,   8'd77}},
      '{rhc_pkg::MODE_HSL, 8'd10,  8'd200, 8'd90,  0, none},
      '{rhc_pkg::MODE_HSI, 8'd0,   8'd0,   8'd0,   1, '{9'd0,   8'd0,   8'd0}},
      '{rhc_pkg::MODE_HSI, 8'd255, 8'd255, 8'd255, 1, '{9'd0,   8'd0,   8'd255}},
      '{rhc_pkg::MODE_HSI, 8'd1,   8'd0,   8'd0,   0, none},
      '{rhc_pkg::MODE_HSI, 8'd2,   8'd0,   8'd0,   0, none},
      '{rhc_pkg::MODE_HSI, 8'd0,   8'd0,   8'd255, 1, '{9'd240, 8'd255, 8'd85}},
      '{rhc_pkg::MODE_HSI, 8'd33,  8'd140, 8'd250, 0, none},
      '{2'd3,              8'd255, 8'd0,   8'd0,   1, '{9'd0,   8'd255, 8'd85}},
      '{2'd3,              8'd12,  8'd34,  8'd56,  0, none}
    };
    foreach (rows[i]) begin
      row = rows[i];
      if (row.mode != mode_shadow) begin
        idle_pixel();
        drain();
        reg_write(rhc_pkg::REG_MODE << 2, {30'd0, row.mode});
      end
      send_pixel(row.r, row.g, row.b, row.known, row.res);
    end
    idle_pixel();
    drain();
    // Unmapped register: must leave the mode alone
    reg_write(3'd4, 32'h0000_0001);

    // Random part in four mode phases, long hold-off in the first
    modes = '{rhc_pkg::MODE_HSL, rhc_pkg::MODE_HSV, rhc_pkg::MODE_HSI, 2'd3};
    for (int p = 0; p < 4; p++) begin
      idle_pixel();
      drain();
      reg_write(rhc_pkg::REG_MODE << 2, {30'd0, modes[p]});
      if (p == 0) hold_long = 1'b1;
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        k = $urandom_range(0, 9);
        if (k < 6) begin
          send_pixel($urandom, $urandom, $urandom, 0, none);
        end else if (k < 8) begin
          // Narrow spread: near gray, near-degenerate quotients
          lo = $urandom;
          mid = (lo > PMAX - 3) ? lo - 3 : lo;
          send_pixel(mid + $urandom_range(0, 3), mid + $urandom_range(0, 3),
                     mid + $urandom_range(0, 3), 0, none);
        end else begin
          // Extremes mixed with random channels
          hi = $urandom_range(0, 1) ? PMAX : 0;
          lo = $urandom;
          case ($urandom_range(0, 2))
            0: send_pixel(hi, lo, $urandom_range(0, 1) ? PMAX : 0, 0, none);
            1: send_pixel(lo, hi, $urandom, 0, none);
            default: send_pixel($urandom, lo, hi, 0, none);
          endcase
        end
      end
    end
    idle_pixel();
    drain();
    if (mismatches == 0 && spurious == 0 && hsx_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
